FILE: rtl/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the buffer cache bookkeeping core.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int KIND_W = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_PIN     = 2'd2,
        KIND_UNPIN   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_UNDER  = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HIT,
        S_VICTIM,
        S_UPD,
        S_MOVE
    } t_state;

    // command transaction
    typedef struct packed {
        t_kind              kind;
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block_number;
        logic [SLOT_W-1:0]  slot;
    } t_cmd;

    // result transaction
    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic               was_valid;
        t_status            status;
        logic [CNT_W-1:0]   ref_count;
    } t_rsp;

    // one slot memory entry
    typedef struct packed {
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block;
        logic               valid;
        logic [CNT_W-1:0]   count;
    } t_entry;

    typedef struct packed {
        t_kind              kind;
        logic               fill;
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block;
    } t_upd_req;

    typedef struct packed {
        t_entry             entry;
        logic               wr;
        logic               was_valid;
        t_status            status;
        logic               move;
    } t_upd_rsp;

endpackage
`default_nettype wire

FILE: rtl/bbc_entry_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_entry_update
// Modify step of the slot memory read-modify-write: reference count, valid
// bit and retag, with the status of the operation.
// ----------------------------------------------------------------------------
module bbc_entry_update (
    input  bbc_pkg::t_upd_req i_req,
    input  bbc_pkg::t_entry   i_entry,
    output bbc_pkg::t_upd_rsp o_rsp
);
    import bbc_pkg::*;

    always_comb begin
        o_rsp           = '0;
        o_rsp.entry     = i_entry;
        o_rsp.status    = ST_OK;
        unique case (i_req.kind)
            KIND_GET: begin
                o_rsp.wr = 1'b1;
                if (i_req.fill) begin
                    // retag a free slot, the disk read is taken as done
                    o_rsp.entry.device = i_req.device;
                    o_rsp.entry.block  = i_req.block;
                    o_rsp.entry.valid  = 1'b1;
                    o_rsp.entry.count  = CNT_W'(1);
                end else begin
                    o_rsp.was_valid   = i_entry.valid;
                    o_rsp.entry.valid = 1'b1;
                    if (i_entry.count == CNT_MAX) begin
                        o_rsp.status = ST_SAT;
                    end else begin
                        o_rsp.entry.count = i_entry.count + CNT_W'(1);
                    end
                end
            end
            KIND_PIN: begin
                if (i_entry.count == CNT_MAX) begin
                    o_rsp.status = ST_SAT;
                end else begin
                    o_rsp.wr          = 1'b1;
                    o_rsp.entry.count = i_entry.count + CNT_W'(1);
                end
            end
            KIND_RELEASE, KIND_UNPIN: begin
                if (i_entry.count == '0) begin
                    o_rsp.status = ST_UNDER;
                end else begin
                    o_rsp.wr          = 1'b1;
                    o_rsp.entry.count = i_entry.count - CNT_W'(1);
                    o_rsp.move        = (i_req.kind == KIND_RELEASE) &&
                                        (i_entry.count == CNT_W'(1));
                end
            end
            default: begin
                o_rsp.wr = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/block_buffer_cache_lru_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_core
// LRU buffer cache bookkeeping: tags, valid bits, reference counts and the
// recency order of NUM_BUFFERS slots.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result shows on
// o_rsp for one cycle with o_done high; the receiver always takes it.
// Slot state sits in a slot memory (tag, valid, count) and a recency memory
// (position -> slot), both with a registered read port.
// get: the hit scan walks positions from most recent, one per cycle through
// a two-deep read pipeline. A miss runs the victim scan from least recent
// for a slot with a zero count.
// pin, unpin, release: the slot is read, then updated. A release that drops
// the count to zero answers, then stays busy while the slot is moved to the
// front.
// After reset the block clears the slot memory and loads the recency memory,
// one entry per cycle, and stays busy in S_INIT until both are written.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_core #(
    parameter int NUM_BUFFERS = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  bbc_pkg::t_cmd  i_cmd,
    output logic           o_done,
    output bbc_pkg::t_rsp  o_rsp
);
    import bbc_pkg::*;

    localparam int SW = $clog2(NUM_BUFFERS);
    localparam int PW = SW + 1;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [SW-1:0]   r_idx, n_idx;
    logic [PW-1:0]   r_ipos, n_ipos;
    logic [PW-1:0]   r_left, n_left;
    logic            r_p1_v, n_p1_v;
    logic            r_p1_last, n_p1_last;
    logic [SW-1:0]   r_p1_pos, n_p1_pos;
    logic            r_p2_v, n_p2_v;
    logic            r_p2_last, n_p2_last;
    logic [SW-1:0]   r_p2_slot, n_p2_slot;
    logic [SW-1:0]   r_prev, n_prev;
    logic            r_done, n_done;
    t_rsp            r_rsp, n_rsp;

    t_entry          slot_mem [NUM_BUFFERS];
    logic [SW-1:0]   order_mem [NUM_BUFFERS];
    t_entry          r_slot_q;
    logic [SW-1:0]   r_order_q;

    logic            w_slot_we;
    logic [SW-1:0]   w_slot_wa;
    t_entry          w_slot_wd;
    logic [SW-1:0]   w_slot_ra;
    logic            w_order_we;
    logic [SW-1:0]   w_order_wa;
    logic [SW-1:0]   w_order_wd;
    logic [SW-1:0]   w_order_ra;

    t_upd_req        w_upd_req;
    t_upd_rsp        w_upd_rsp;
    logic            w_issue;
    logic            w_tag_eq;

    bbc_entry_update u_upd (
        .i_req   (w_upd_req),
        .i_entry (r_slot_q),
        .o_rsp   (w_upd_rsp)
    );

    // slot memory and recency memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            slot_mem[w_slot_wa] <= w_slot_wd;
        end
        r_slot_q <= slot_mem[w_slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_order_we) begin
            order_mem[w_order_wa] <= w_order_wd;
        end
        r_order_q <= order_mem[w_order_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ipos  <= '0;
            r_left  <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ipos  <= n_ipos;
            r_left  <= n_left;
            r_p1_v  <= n_p1_v;
            r_p2_v  <= n_p2_v;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_p1_last <= n_p1_last;
        r_p1_pos  <= n_p1_pos;
        r_p2_last <= n_p2_last;
        r_p2_slot <= n_p2_slot;
        r_prev    <= n_prev;
        r_rsp     <= n_rsp;
    end

    assign w_tag_eq = (r_slot_q.device == r_cmd.device) &&
                      (r_slot_q.block == r_cmd.block_number);
    assign w_issue  = (r_left != '0);

    always_comb begin
        w_upd_req.kind   = ((r_state == S_HIT) || (r_state == S_VICTIM)) ? KIND_GET
                                                                        : r_cmd.kind;
        w_upd_req.fill   = (r_state == S_VICTIM);
        w_upd_req.device = r_cmd.device;
        w_upd_req.block  = r_cmd.block_number;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_ipos     = r_ipos;
        n_left     = r_left;
        n_p1_v     = 1'b0;
        n_p1_last  = r_p1_last;
        n_p1_pos   = r_p1_pos;
        n_p2_v     = 1'b0;
        n_p2_last  = r_p2_last;
        n_p2_slot  = r_p2_slot;
        n_prev     = r_prev;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        w_slot_we  = 1'b0;
        w_slot_wa  = r_p2_slot;
        w_slot_wd  = w_upd_rsp.entry;
        w_slot_ra  = r_order_q;
        w_order_we = 1'b0;
        w_order_wa = r_p1_pos;
        w_order_wd = r_prev;
        w_order_ra = r_ipos[SW-1:0];

        // position issue for the scans and the move
        if ((r_state == S_HIT) || (r_state == S_VICTIM) || (r_state == S_MOVE)) begin
            n_p1_v    = w_issue;
            n_p1_pos  = r_ipos[SW-1:0];
            n_p1_last = (r_left == PW'(1));
            if (w_issue) begin
                n_left = r_left - PW'(1);
                n_ipos = (r_state == S_VICTIM) ? r_ipos - PW'(1) : r_ipos + PW'(1);
            end
        end
        if ((r_state == S_HIT) || (r_state == S_VICTIM)) begin
            n_p2_v    = r_p1_v;
            n_p2_slot = r_order_q;
            n_p2_last = r_p1_last;
        end

        unique case (r_state)
            S_INIT: begin
                w_slot_we  = 1'b1;
                w_slot_wa  = r_ipos[SW-1:0];
                w_slot_wd  = '0;
                w_order_we = 1'b1;
                w_order_wa = r_ipos[SW-1:0];
                w_order_wd = SW'(NUM_BUFFERS - 1) - r_ipos[SW-1:0];
                n_ipos     = r_ipos + PW'(1);
                if (r_ipos == PW'(NUM_BUFFERS - 1)) begin
                    n_state = S_IDLE;
                    n_ipos  = '0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_idx     = SW'(i_cmd.slot);
                    w_slot_ra = SW'(i_cmd.slot);
                    if (i_cmd.kind == KIND_GET) begin
                        n_state = S_HIT;
                        n_ipos  = '0;
                        n_left  = PW'(NUM_BUFFERS);
                    end else if (32'(i_cmd.slot) >= 32'(NUM_BUFFERS)) begin
                        // slot beyond the cache: answered as is
                        n_done          = 1'b1;
                        n_rsp.slot_out  = i_cmd.slot;
                        n_rsp.was_valid = 1'b0;
                        n_rsp.status    = ST_OK;
                        n_rsp.ref_count = '0;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_HIT: begin
                if (r_p2_v && w_tag_eq) begin
                    w_slot_we       = w_upd_rsp.wr;
                    n_done          = 1'b1;
                    n_rsp.slot_out  = SLOT_W'(r_p2_slot);
                    n_rsp.was_valid = w_upd_rsp.was_valid;
                    n_rsp.status    = w_upd_rsp.status;
                    n_rsp.ref_count = w_upd_rsp.entry.count;
                    n_state         = S_IDLE;
                    n_p1_v          = 1'b0;
                    n_p2_v          = 1'b0;
                    n_left          = '0;
                end else if (r_p2_v && r_p2_last) begin
                    // no tag match: look for the least recent free slot
                    n_state = S_VICTIM;
                    n_ipos  = PW'(NUM_BUFFERS - 1);
                    n_left  = PW'(NUM_BUFFERS);
                    n_p1_v  = 1'b0;
                    n_p2_v  = 1'b0;
                end
            end
            S_VICTIM: begin
                if (r_p2_v && (r_slot_q.count == '0)) begin
                    w_slot_we       = w_upd_rsp.wr;
                    n_done          = 1'b1;
                    n_rsp.slot_out  = SLOT_W'(r_p2_slot);
                    n_rsp.was_valid = 1'b0;
                    n_rsp.status    = w_upd_rsp.status;
                    n_rsp.ref_count = w_upd_rsp.entry.count;
                    n_state         = S_IDLE;
                    n_p1_v          = 1'b0;
                    n_p2_v          = 1'b0;
                    n_left          = '0;
                end else if (r_p2_v && r_p2_last) begin
                    n_done          = 1'b1;
                    n_rsp.slot_out  = '0;
                    n_rsp.was_valid = 1'b0;
                    n_rsp.status    = ST_NOFREE;
                    n_rsp.ref_count = '0;
                    n_state         = S_IDLE;
                    n_p1_v          = 1'b0;
                    n_p2_v          = 1'b0;
                end
            end
            S_UPD: begin
                w_slot_we       = w_upd_rsp.wr;
                w_slot_wa       = r_idx;
                n_done          = 1'b1;
                n_rsp.slot_out  = r_cmd.slot;
                n_rsp.was_valid = 1'b0;
                n_rsp.status    = w_upd_rsp.status;
                n_rsp.ref_count = w_upd_rsp.entry.count;
                if (w_upd_rsp.move) begin
                    n_state = S_MOVE;
                    n_ipos  = '0;
                    n_left  = PW'(NUM_BUFFERS);
                    n_prev  = r_idx;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MOVE: begin
                // shift each entry down by one until the slot's old position
                if (r_p1_v) begin
                    w_order_we = 1'b1;
                    n_prev     = r_order_q;
                    if ((r_order_q == r_idx) || r_p1_last) begin
                        n_state = S_IDLE;
                        n_p1_v  = 1'b0;
                        n_left  = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_done)
        else $error("result during memory clear");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command neither busy nor answered");

    a_nofree_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_NOFREE)) |->
            ((o_rsp.slot_out == '0) && (o_rsp.ref_count == '0) && !o_rsp.was_valid))
        else $error("no free buffer result carries data");

    a_sat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_SAT)) |-> (o_rsp.ref_count == CNT_MAX))
        else $error("saturated status with count below max");

    a_under_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_UNDER)) |-> (o_rsp.ref_count == '0))
        else $error("underflow status with nonzero count");

endmodule
`default_nettype wire
